// ===== design/occupancy_grid_obstacle_inflation_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the occupancy grid inflation block
// Concurrent checks clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_OBSTACLE_INFLATION_TOP_MACROS_SVH
`define OCCUPANCY_GRID_OBSTACLE_INFLATION_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define OGI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define OGI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== design/ogi_pkg.sv =====
// ----------------------------------------------------------------------------
// ogi_pkg
// Types and constants of the occupancy grid inflation block.
// ----------------------------------------------------------------------------
`default_nettype none

package ogi_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_MAX_RADIUS = 8;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS     = 2'd2;

	localparam logic [10:0] RST_MAP_WIDTH  = 11'd1024;
	localparam logic [12:0] RST_MAP_HEIGHT = 13'd1024;
	localparam logic [3:0]  RST_RADIUS     = 4'd2;

	localparam logic       CMD_FLUSH = 1'b1;
	localparam logic [7:0] OBSTACLE  = 8'd100;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_CEN,
		ST_SCAN,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== design/occupancy_grid_obstacle_inflation_top.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_inflation_top
// Streaming disk inflation of an occupancy grid in raster order.
// ----------------------------------------------------------------------------
// Cells enter in raster order and leave delayed by radius*width+radius
// positions; a cell leaves as 100 when any in-map obstacle (exactly 100) lies
// within squared distance radius^2, else with its own value. Flush transfers
// (tuser=1) after the last cell push out the tail; tlast marks the final cell.
// Timing: one item at a time. An item that gives no result only writes the
// store. An item that gives a result reads its own cell, then scans the window,
// stopping early when an obstacle is found: the window is scanned one cell per
// cycle through the single read port of the cell store, a circular buffer of
// (2*MAX_RADIUS+1)*MAX_WIDTH cells addressed by map position. A finished
// result waits in the output register while the next item is taken. Config
// writes reset the map position; write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "occupancy_grid_obstacle_inflation_top_macros.svh"

module occupancy_grid_obstacle_inflation_top #(
	parameter int MAX_WIDTH  = ogi_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ogi_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = ogi_pkg::DEF_MAX_RADIUS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// config port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	// input stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic signed [7:0] s_axis_tdata,   // [7:0] cell_value
	input  wire logic              s_axis_tuser,   // [0] cmd
	// output stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic signed [7:0]      m_axis_tdata,   // [7:0] out_cell_value
	output logic                   m_axis_tlast    // last_cell
);

	localparam int SLOTS = 2 * MAX_RADIUS + 1;
	localparam int DEPTH = SLOTS * MAX_WIDTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_RADIUS + 2);
	localparam int OW    = RW + 1;
	localparam int SQW   = 2 * OW + 1;
	localparam int NXW   = ((WW > OW) ? WW : OW) + 2;
	localparam int NYW   = ((HW > OW) ? HW : OW) + 2;
	localparam int PW    = ((AW > WW) ? AW : WW) + 2;
	localparam int PCW   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
		+ MAX_RADIUS + 1);

	// ---------------- configuration ----------------
	logic [10:0] cfg_width_q;
	logic [12:0] cfg_height_q;
	logic [3:0]  cfg_radius_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= ogi_pkg::RST_MAP_WIDTH;
			cfg_height_q <= ogi_pkg::RST_MAP_HEIGHT;
			cfg_radius_q <= ogi_pkg::RST_RADIUS;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ogi_pkg::REG_MAP_WIDTH:  cfg_width_q  <= pwdata[10:0];
				ogi_pkg::REG_MAP_HEIGHT: cfg_height_q <= pwdata[12:0];
				ogi_pkg::REG_RADIUS:     cfg_radius_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ogi_pkg::REG_MAP_WIDTH:  prdata = {21'd0, cfg_width_q};
			ogi_pkg::REG_MAP_HEIGHT: prdata = {19'd0, cfg_height_q};
			ogi_pkg::REG_RADIUS:     prdata = {28'd0, cfg_radius_q};
			default:                 prdata = 32'd0;
		endcase
	end

	// a write to a known register abandons the map in progress
	logic cfg_restart;
	assign cfg_restart = cfg_wr && (paddr[3:2] == ogi_pkg::REG_MAP_WIDTH
		|| paddr[3:2] == ogi_pkg::REG_MAP_HEIGHT || paddr[3:2] == ogi_pkg::REG_RADIUS);

	// clamped working values
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [RW-1:0] r_eff;

	always_comb begin
		if (cfg_width_q == 11'd0)                  w_eff = WW'(1);
		else if (32'(cfg_width_q) > MAX_WIDTH)     w_eff = WW'(MAX_WIDTH);
		else                                       w_eff = WW'(cfg_width_q);
		if (cfg_height_q == 13'd0)                 h_eff = HW'(1);
		else if (32'(cfg_height_q) > MAX_HEIGHT)   h_eff = HW'(MAX_HEIGHT);
		else                                       h_eff = HW'(cfg_height_q);
		if (32'(cfg_radius_q) > MAX_RADIUS)        r_eff = RW'(MAX_RADIUS);
		else                                       r_eff = RW'(cfg_radius_q);
	end

	// map size, output lag and window row offset, registered off the config path
	logic [PCW-1:0] total_q;
	logic [PCW-1:0] lag_q;
	logic [PW-1:0]  rw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= PCW'(1);
			lag_q   <= '0;
			rw_q    <= '0;
		end else begin
			total_q <= PCW'(w_eff) * PCW'(h_eff);
			lag_q   <= PCW'(r_eff) * PCW'(w_eff) + PCW'(r_eff);
			rw_q    <= PW'(r_eff) * PW'(w_eff);
		end
	end

	// ---------------- sequencer ----------------
	ogi_pkg::state_t state_q, state_d;

	logic           cmd_q;
	logic [7:0]     val_q;
	logic [PCW-1:0] pos_q, emit_q;
	logic [CW-1:0]  qx_q;
	logic [YW-1:0]  qy_q;
	logic [AW-1:0]  wr_ptr_q, q_ptr_q, row_ptr_q;
	logic signed [OW-1:0] dx_q, dy_q;
	logic           issue_done_q, qual_s1, last_s1, cen_s1;
	logic [7:0]     own_q, res_q, rd_q;
	logic           out_valid_q;
	logic [7:0]     out_data_q;
	logic           out_last_q;

	logic s_fire, in_map, out_free, hit, last_cell;
	logic mem_we;
	logic [AW-1:0] rd_addr;

	assign s_fire    = s_axis_tvalid & s_axis_tready;
	assign in_map    = pos_q < total_q;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign hit       = qual_s1 && (rd_q == ogi_pkg::OBSTACLE);
	assign last_cell = PCW'(emit_q + 1'b1) >= total_q;
	assign mem_we    = (state_q == ogi_pkg::ST_WRITE) && in_map && (cmd_q != ogi_pkg::CMD_FLUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ogi_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ogi_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_fire) state_d = ogi_pkg::ST_WRITE;
			end
			ogi_pkg::ST_WRITE: begin
				if (in_map && cmd_q == ogi_pkg::CMD_FLUSH) state_d = ogi_pkg::ST_IDLE;
				else if (pos_q < lag_q)                   state_d = ogi_pkg::ST_IDLE;
				else                                      state_d = ogi_pkg::ST_CEN;
			end
			ogi_pkg::ST_CEN: state_d = ogi_pkg::ST_SCAN;
			ogi_pkg::ST_SCAN: begin
				if (hit || last_s1) state_d = ogi_pkg::ST_OUT;
			end
			ogi_pkg::ST_OUT: begin
				if (out_free) state_d = ogi_pkg::ST_IDLE;
			end
			default: state_d = ogi_pkg::ST_IDLE;
		endcase
	end

	// ---------------- neighbor address ----------------
	logic signed [NXW-1:0] nx;
	logic signed [NYW-1:0] ny;
	logic signed [SQW-1:0] dxs, dys, rs;
	logic                  in_bounds, in_disk, scan_last;
	logic [PW-1:0]         row_start, row_start_w, row_next, row_next_w;
	logic signed [PW-1:0]  nbr_raw;
	logic [AW-1:0]         nbr_addr;

	always_comb begin
		nx  = NXW'(signed'({1'b0, qx_q})) + NXW'(dx_q);
		ny  = NYW'(signed'({1'b0, qy_q})) + NYW'(dy_q);
		dxs = SQW'(dx_q);
		dys = SQW'(dy_q);
		rs  = SQW'(signed'({1'b0, r_eff}));
		in_bounds = (nx >= 0) && (nx < NXW'(signed'({1'b0, w_eff})))
			&& (ny >= 0) && (ny < NYW'(signed'({1'b0, h_eff})));
		in_disk   = (dxs * dxs + dys * dys) <= (rs * rs);
		scan_last = (dx_q == OW'(signed'({1'b0, r_eff})))
			&& (dy_q == OW'(signed'({1'b0, r_eff})));
		// top window row: output position minus r rows, modulo store depth
		row_start = PW'(q_ptr_q) + PW'(DEPTH) - rw_q;
		if (row_start >= PW'(DEPTH)) row_start_w = row_start - PW'(DEPTH);
		else                         row_start_w = row_start;
		// next window row is one map width further on
		row_next = PW'(row_ptr_q) + PW'(w_eff);
		if (row_next >= PW'(DEPTH)) row_next_w = row_next - PW'(DEPTH);
		else                        row_next_w = row_next;
		// column offset within the current row, wrapped around the ring
		nbr_raw = signed'(PW'(row_ptr_q)) + PW'(dx_q);
		if (nbr_raw < 0)                  nbr_addr = AW'(nbr_raw + PW'(DEPTH));
		else if (nbr_raw >= PW'(DEPTH))   nbr_addr = AW'(nbr_raw - PW'(DEPTH));
		else                              nbr_addr = AW'(nbr_raw);
	end

	always_comb begin
		if (state_q == ogi_pkg::ST_CEN) rd_addr = q_ptr_q;
		else                            rd_addr = nbr_addr;
	end

	// cell store
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_ptr_q] <= val_q;
		rd_q <= mem[rd_addr];
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q <= s_axis_tuser;
			val_q <= s_axis_tdata;
		end
		if (cen_s1) own_q <= rd_q;
		if (state_q == ogi_pkg::ST_SCAN && (hit || last_s1))
			res_q <= hit ? ogi_pkg::OBSTACLE : own_q;
	end

	logic scan_issue, out_load;
	assign scan_issue = (state_q == ogi_pkg::ST_SCAN) && !issue_done_q;
	assign out_load   = (state_q == ogi_pkg::ST_OUT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			emit_q       <= '0;
			wr_ptr_q     <= '0;
			q_ptr_q      <= '0;
			row_ptr_q    <= '0;
			qx_q         <= '0;
			qy_q         <= '0;
			dx_q         <= '0;
			dy_q         <= '0;
			issue_done_q <= 1'b0;
			qual_s1      <= 1'b0;
			last_s1      <= 1'b0;
			cen_s1       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_last_q   <= 1'b0;
		end else begin
			// output register
			if (out_load)                          out_valid_q <= 1'b1;
			else if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (out_load) begin
				out_data_q <= res_q;
				out_last_q <= last_cell;
			end

			// window scan: one neighbor read per cycle
			qual_s1 <= scan_issue && in_bounds && in_disk;
			last_s1 <= scan_issue && scan_last;
			cen_s1  <= (state_q == ogi_pkg::ST_CEN);

			if (state_q == ogi_pkg::ST_CEN)   issue_done_q <= 1'b0;
			else if (scan_issue && scan_last) issue_done_q <= 1'b1;

			if (state_q == ogi_pkg::ST_CEN) begin
				dx_q      <= -OW'(signed'({1'b0, r_eff}));
				dy_q      <= -OW'(signed'({1'b0, r_eff}));
				row_ptr_q <= AW'(row_start_w);
			end else if (scan_issue && !scan_last) begin
				if (dx_q == OW'(signed'({1'b0, r_eff}))) begin
					dx_q      <= -OW'(signed'({1'b0, r_eff}));
					dy_q      <= dy_q + 1'b1;
					row_ptr_q <= AW'(row_next_w);
				end else begin
					dx_q <= dx_q + 1'b1;
				end
			end

			// map position counters
			if (cfg_restart) begin
				pos_q    <= '0;
				emit_q   <= '0;
				wr_ptr_q <= '0;
				q_ptr_q  <= '0;
				qx_q     <= '0;
				qy_q     <= '0;
			end else if (state_q == ogi_pkg::ST_WRITE) begin
				if (!(in_map && cmd_q == ogi_pkg::CMD_FLUSH)) pos_q <= pos_q + 1'b1;
				if (mem_we)
					wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end else if (out_load) begin
				if (last_cell) begin
					// end of map: next item opens a new map
					pos_q    <= '0;
					emit_q   <= '0;
					wr_ptr_q <= '0;
					q_ptr_q  <= '0;
					qx_q     <= '0;
					qy_q     <= '0;
				end else begin
					emit_q  <= emit_q + 1'b1;
					q_ptr_q <= (q_ptr_q == AW'(DEPTH - 1)) ? '0 : q_ptr_q + 1'b1;
					if (qx_q == CW'(w_eff - 1'b1)) begin
						qx_q <= '0;
						qy_q <= qy_q + 1'b1;
					end else begin
						qx_q <= qx_q + 1'b1;
					end
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	// ---------------- assertions ----------------
	`OGI_ASSERT_ALWAYS(a_emit_behind_pos, emit_q <= pos_q, "emitted passed positions")
	`OGI_ASSERT_IMPLIES(a_write_in_map, mem_we, pos_q < total_q, "store write past map end")
	`OGI_ASSERT_ALWAYS(a_col_in_row, 32'(qx_q) < 32'(w_eff), "output column beyond row")

endmodule

`default_nettype wire
